// ----- hw/rtl/tfn_pkg.sv -----
// Shared types and constants of the triangle face normal marker.
package tfn_pkg;

    // Field widths that the interface fixes.
    localparam int CW       = 32;
    localparam int LEN_W    = 23;
    localparam int CORNER_W = 10;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TRI  = 1'b1;

    // Normal length after reset: 0.3 in unsigned Q7.16.
    localparam logic [LEN_W-1:0] LEN_RESET = 23'd19661;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vtx;

    // One queued input item.
    typedef struct packed {
        logic                kind;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        t_coord              x;
        t_coord              y;
        t_coord              z;
        logic                last;
    } t_item;

    // Three fetched corners of one triangle.
    typedef struct packed {
        t_vtx a;
        t_vtx b;
        t_vtx c;
        logic last;
    } t_tri;

    // One finished result.
    typedef struct packed {
        t_coord [2:0] cen;
        t_coord [2:0] tip;
        logic         degen;
        logic         last;
    } t_res;

endpackage

// ----- hw/rtl/triangle_face_normal_marker_unit.sv -----
// Top level of the triangle face normal marker.
//
// Items enter through a four-entry queue: o_busy is high only while that queue
// is full, and an item is taken at a clock edge where i_start is high and
// o_busy is low. The back end drains the queue in order through one
// single-port vertex RAM: a load item is one write, a triangle is one read
// per corner, and the next item is taken only after the third read is issued,
// so loads interleave between triangles at one per cycle. The arithmetic after
// the reads is fully pipelined. Each result is shown for exactly one cycle
// and cannot be held off. The vertex store needs no clearing after reset; a
// slot must be loaded before a triangle names it. Write the normal length
// only while no triangle is in flight.
module triangle_face_normal_marker_unit
    import tfn_pkg::*;
#(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_kind,
    input  logic [CORNER_W-1:0] i_corner_a,
    input  logic [CORNER_W-1:0] i_corner_b,
    input  logic [CORNER_W-1:0] i_corner_c,
    input  logic signed [CW-1:0] i_coord_x,
    input  logic signed [CW-1:0] i_coord_y,
    input  logic signed [CW-1:0] i_coord_z,
    input  logic                i_last_triangle,
    input  logic                i_cfg_we,
    input  logic [LEN_W-1:0]    i_cfg_data,
    output logic                o_valid,
    output logic signed [CW-1:0] o_center_x,
    output logic signed [CW-1:0] o_center_y,
    output logic signed [CW-1:0] o_center_z,
    output logic signed [CW-1:0] o_tip_x,
    output logic signed [CW-1:0] o_tip_y,
    output logic signed [CW-1:0] o_tip_z,
    output logic                o_degenerate,
    output logic                o_last
);

    localparam int SW = $clog2(VERTEX_SLOTS);

    logic [LEN_W-1:0] r_len;
    logic             push;
    t_item            in_item;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    logic             ram_we;
    logic [SW-1:0]    ram_addr;
    t_vtx             ram_wdata;
    t_vtx             ram_rdata;
    logic             tri_valid;
    t_tri             tri_data;
    t_res             res;

    // Normal length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // A transfer happens when start meets a queue with room.
    assign push    = i_start && !o_busy;
    assign in_item = '{kind: i_kind, corner_a: i_corner_a, corner_b: i_corner_b,
                       corner_c: i_corner_c, x: i_coord_x, y: i_coord_y,
                       z: i_coord_z, last: i_last_triangle};

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (o_busy),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    tfn_seq #(
        .VERTEX_SLOTS (VERTEX_SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_valid     (tri_valid),
        .o_tri       (tri_data)
    );

    tfn_ram #(
        .WIDTH ($bits(t_vtx)),
        .DEPTH (VERTEX_SLOTS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    tfn_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tri_valid),
        .i_tri   (tri_data),
        .i_len   (r_len),
        .o_valid (o_valid),
        .o_res   (res)
    );

    // Result ports.
    assign o_center_x   = res.cen[0];
    assign o_center_y   = res.cen[1];
    assign o_center_z   = res.cen[2];
    assign o_tip_x      = res.tip[0];
    assign o_tip_y      = res.tip[1];
    assign o_tip_z      = res.tip[2];
    assign o_degenerate = res.degen;
    assign o_last       = res.last;

endmodule

// ----- hw/rtl/tfn_ram.sv -----
// Generic single-port RAM with registered read data.
module tfn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A write takes the port for the cycle; otherwise the addressed word is read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

// ----- hw/rtl/tfn_front.sv -----
// Front end: a short queue that takes in items while the back end works.
module tfn_front
    import tfn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    t_item          r_q [QD];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{PW{1'b0}}, i_push} - {{PW{1'b0}}, i_pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

// ----- hw/rtl/tfn_seq.sv -----
// Back end sequencer: writes loaded vertices and fetches the three corners of a triangle.
module tfn_seq
    import tfn_pkg::*;
#(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  t_item                           i_item,
    output logic                            o_pop,
    output logic                            o_ram_we,
    output logic [$clog2(VERTEX_SLOTS)-1:0] o_ram_addr,
    output t_vtx                            o_ram_wdata,
    input  t_vtx                            i_ram_rdata,
    output logic                            o_valid,
    output t_tri                            o_tri
);

    localparam int SW = $clog2(VERTEX_SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_RD_B, S_RD_C} t_state;
    typedef enum logic [1:0] {G_NONE, G_A, G_B, G_C} t_got;

    t_state        r_state;
    t_got          r_got;
    logic [SW-1:0] r_slot_b;
    logic [SW-1:0] r_slot_c;
    logic          r_last;
    t_vtx          r_va;
    t_vtx          r_vb;
    logic          tri_go;

    // Reduces a corner index into the slot range by conditional subtraction.
    function automatic logic [SW-1:0] f_slot(input logic [CORNER_W-1:0] c);
        logic [CORNER_W:0] v;
        v = {1'b0, c};
        for (int k = CORNER_W - 1; k >= 0; k--) begin
            if (((32'(VERTEX_SLOTS) << k) <= 32'd1023)
                && ({21'd0, v} >= (32'(VERTEX_SLOTS) << k))) begin
                v = v - (CORNER_W+1)'(32'(VERTEX_SLOTS) << k);
            end
        end
        return SW'(v);
    endfunction

    // Take a new item only between triangles.
    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign tri_go      = o_pop && (i_item.kind == KIND_TRI);
    assign o_ram_we    = o_pop && (i_item.kind == KIND_LOAD);
    assign o_ram_wdata = '{x: i_item.x, y: i_item.y, z: i_item.z};

    // Port address: corner a when an item is taken, then corners b and c.
    always_comb begin
        case (r_state)
            S_RD_B:  o_ram_addr = r_slot_b;
            S_RD_C:  o_ram_addr = r_slot_c;
            default: o_ram_addr = f_slot(i_item.corner_a);
        endcase
    end

    // State and read tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_got   <= G_NONE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_state <= tri_go ? S_RD_B : S_IDLE;
                    r_got   <= tri_go ? G_A : G_NONE;
                end
                S_RD_B: begin
                    r_state <= S_RD_C;
                    r_got   <= G_B;
                end
                S_RD_C: begin
                    r_state <= S_IDLE;
                    r_got   <= G_C;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_got   <= G_NONE;
                end
            endcase
        end
    end

    // Corner slots and fetched vertices.
    always_ff @(posedge i_clk) begin
        if (tri_go) begin
            r_slot_b <= f_slot(i_item.corner_b);
            r_slot_c <= f_slot(i_item.corner_c);
            r_last   <= i_item.last;
        end
        if (r_got == G_A) begin
            r_va <= i_ram_rdata;
        end
        if (r_got == G_B) begin
            r_vb <= i_ram_rdata;
        end
    end

    // The third corner comes straight from the RAM output register.
    assign o_valid = (r_got == G_C);
    assign o_tri   = '{a: r_va, b: r_vb, c: i_ram_rdata, last: r_last};

endmodule

// ----- hw/rtl/tfn_math.sv -----
// Back end arithmetic pipeline: centroid, cross product, normalization, norm and offset.
module tfn_math
    import tfn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_tri             i_tri,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_valid,
    output t_res             o_res
);

    localparam int NORM_STEPS = 6;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 23;
    // 2^17 = 3 * THIRD_HI + 2, and THIRD_LO = ceil(2^20 / 3).
    localparam logic [31:0] THIRD_HI = 32'd43690;
    localparam logic [36:0] THIRD_LO = 37'd349526;

    typedef struct packed {
        t_coord [2:0] cen;
        logic   [2:0] neg;
        logic         degen;
        logic         last;
    } t_side;

    t_coord va [3];
    t_coord vb [3];
    t_coord vc [3];

    always_comb begin
        va[0] = i_tri.a.x; va[1] = i_tri.a.y; va[2] = i_tri.a.z;
        vb[0] = i_tri.b.x; vb[1] = i_tri.b.y; vb[2] = i_tri.b.z;
        vc[0] = i_tri.c.x; vc[1] = i_tri.c.y; vc[2] = i_tri.c.z;
    end

    // Stage 1: coordinate sums and edge vectors.
    logic               r1_v;
    logic               r1_last;
    logic signed [33:0] r1_sum [3];
    logic signed [32:0] r1_e [3];
    logic signed [32:0] r1_f [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_sum[i] <= 34'(va[i]) + 34'(vb[i]) + 34'(vc[i]);
            r1_e[i]   <= 33'(vb[i]) - 33'(va[i]);
            r1_f[i]   <= 33'(vc[i]) - 33'(va[i]);
        end
        r1_last <= i_tri.last;
    end

    // Stage 2: edge reduction below 2^31 and the first half of the divide by three.
    logic [32:0] me [3];
    logic [32:0] mf [3];
    logic [31:0] ke [3];
    logic [31:0] kf [3];
    logic [33:0] asum [3];
    logic [32:0] u [3];
    logic        shr;

    always_comb begin
        shr = 1'b0;
        for (int i = 0; i < 3; i++) begin
            me[i]   = r1_e[i][32] ? 33'(-r1_e[i]) : 33'(r1_e[i]);
            mf[i]   = r1_f[i][32] ? 33'(-r1_f[i]) : 33'(r1_f[i]);
            shr     = shr | me[i][32] | me[i][31] | mf[i][32] | mf[i][31];
            asum[i] = r1_sum[i][33] ? 34'(-r1_sum[i]) : 34'(r1_sum[i]);
            u[i]    = asum[i][32:0] + 33'd1;
        end
        for (int i = 0; i < 3; i++) begin
            ke[i] = shr ? me[i][32:1] : me[i][31:0];
            kf[i] = shr ? mf[i][32:1] : mf[i][31:0];
        end
    end

    logic               r2_v;
    logic               r2_last;
    logic signed [31:0] r2_e [3];
    logic signed [31:0] r2_f [3];
    logic [31:0]        r2_p [3];
    logic [17:0]        r2_r1 [3];
    logic [2:0]         r2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_e[i]   <= r1_e[i][32] ? -$signed(ke[i]) : $signed(ke[i]);
            r2_f[i]   <= r1_f[i][32] ? -$signed(kf[i]) : $signed(kf[i]);
            r2_p[i]   <= 32'(u[i][32:17]) * THIRD_HI;
            r2_r1[i]  <= 18'({u[i][32:17], 1'b0}) + 18'(u[i][16:0]);
            r2_neg[i] <= r1_sum[i][33];
        end
        r2_last <= r1_last;
    end

    // Stage 3: cross product terms and the second half of the divide by three.
    logic               r3_v;
    logic               r3_last;
    logic signed [63:0] r3_pp [3];
    logic signed [63:0] r3_pn [3];
    logic [16:0]        r3_t [3];
    logic [31:0]        r3_p [3];
    logic [2:0]         r3_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pp[0] <= 64'(r2_e[1]) * 64'(r2_f[2]);
        r3_pn[0] <= 64'(r2_e[2]) * 64'(r2_f[1]);
        r3_pp[1] <= 64'(r2_e[2]) * 64'(r2_f[0]);
        r3_pn[1] <= 64'(r2_e[0]) * 64'(r2_f[2]);
        r3_pp[2] <= 64'(r2_e[0]) * 64'(r2_f[1]);
        r3_pn[2] <= 64'(r2_e[1]) * 64'(r2_f[0]);
        for (int i = 0; i < 3; i++) begin
            r3_t[i] <= 17'((37'(r2_r1[i]) * THIRD_LO) >> 20);
            r3_p[i] <= r2_p[i];
        end
        r3_neg  <= r2_neg;
        r3_last <= r2_last;
    end

    // Stage 4: cross product and centroid.
    logic [32:0]        q3 [3];
    logic               r4_v;
    logic               r4_last;
    logic signed [63:0] r4_cr [3];
    t_coord             r4_cen [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q3[i] = 33'(r3_p[i]) + 33'(r3_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_cr[i]  <= r3_pp[i] - r3_pn[i];
            r4_cen[i] <= r3_neg[i] ? t_coord'(32'(-q3[i])) : t_coord'(32'(q3[i]));
        end
        r4_last <= r3_last;
    end

    // Stage 5: magnitudes, their OR for the leading one search, degenerate test.
    logic [63:0] mg [3];
    logic [63:0] mor;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mg[i] = r4_cr[i][63] ? 64'(-r4_cr[i]) : 64'(r4_cr[i]);
        end
        mor = mg[0] | mg[1] | mg[2];
    end

    // Normalizer: word 3 is the OR of the three magnitudes, which steers the shifts.
    logic [63:0] r_nw [NORM_STEPS+1][4];
    t_side       r_ns [NORM_STEPS+1];
    logic        r_nv [NORM_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv[0] <= 1'b0;
        end else begin
            r_nv[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_nw[0][i]     <= mg[i];
            r_ns[0].cen[i] <= r4_cen[i];
            r_ns[0].neg[i] <= r4_cr[i][63];
        end
        r_nw[0][3]     <= mor;
        r_ns[0].degen  <= (mor == 64'd0);
        r_ns[0].last   <= r4_last;
    end

    for (genvar gk = 0; gk < NORM_STEPS; gk++) begin : g_norm
        localparam int SH = 32 >> gk;
        logic zt;

        assign zt = ((r_nw[gk][3] >> (64 - SH)) == 64'd0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[gk+1] <= 1'b0;
            end else begin
                r_nv[gk+1] <= r_nv[gk];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int j = 0; j < 4; j++) begin
                r_nw[gk+1][j] <= zt ? (r_nw[gk][j] << SH) : r_nw[gk][j];
            end
            r_ns[gk+1] <= r_ns[gk];
        end
    end

    // Scaled magnitudes: the largest now lies in [2^30, 2^31).
    logic [30:0] mn [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mn[i] = r_nw[NORM_STEPS][i][63:33];
        end
    end

    // Squares of the scaled magnitudes.
    logic        r_qv;
    t_side       r_qs;
    logic [61:0] r_sq [3];
    logic [30:0] r_qm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else begin
            r_qv <= r_nv[NORM_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= 62'(mn[i]) * 62'(mn[i]);
            r_qm[i] <= mn[i];
        end
        r_qs <= r_ns[NORM_STEPS];
    end

    // Integer square root, one result bit per stage.
    logic [33:0] rq_rem  [SQRT_STEPS+1];
    logic [31:0] rq_root [SQRT_STEPS+1];
    logic [63:0] rq_x    [SQRT_STEPS+1];
    logic [30:0] rq_m    [SQRT_STEPS+1][3];
    t_side       rq_s    [SQRT_STEPS+1];
    logic        rq_v    [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq_v[0] <= 1'b0;
        end else begin
            rq_v[0] <= r_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        rq_x[0]    <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        rq_rem[0]  <= '0;
        rq_root[0] <= '0;
        for (int i = 0; i < 3; i++) begin
            rq_m[0][i] <= r_qm[i];
        end
        rq_s[0] <= r_qs;
    end

    for (genvar gj = 0; gj < SQRT_STEPS; gj++) begin : g_sqrt
        logic [35:0] remx;
        logic [35:0] trial;
        logic        ge;

        assign remx  = {rq_rem[gj], rq_x[gj][63:62]};
        assign trial = {2'b00, rq_root[gj], 2'b01};
        assign ge    = (remx >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rq_v[gj+1] <= 1'b0;
            end else begin
                rq_v[gj+1] <= rq_v[gj];
            end
        end

        always_ff @(posedge i_clk) begin
            rq_rem[gj+1]  <= ge ? 34'(remx - trial) : remx[33:0];
            rq_root[gj+1] <= {rq_root[gj][30:0], ge};
            rq_x[gj+1]    <= {rq_x[gj][61:0], 2'b00};
            for (int i = 0; i < 3; i++) begin
                rq_m[gj+1][i] <= rq_m[gj][i];
            end
            rq_s[gj+1] <= rq_s[gj];
        end
    end

    // Offset numerators: length times magnitude.
    logic        rp_v;
    t_side       rp_s;
    logic [53:0] rp_prod [3];
    logic [31:0] rp_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_v <= 1'b0;
        end else begin
            rp_v <= rq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            rp_prod[i] <= 54'(i_len) * 54'(rq_m[SQRT_STEPS][i]);
        end
        rp_n <= rq_root[SQRT_STEPS];
        rp_s <= rq_s[SQRT_STEPS];
    end

    // Restoring divider, one quotient bit per stage, three lanes sharing the norm.
    logic [54:0] rd_rem [DIV_STEPS+1][3];
    logic [22:0] rd_q   [DIV_STEPS+1][3];
    logic [31:0] rd_n   [DIV_STEPS+1];
    t_side       rd_s   [DIV_STEPS+1];
    logic        rd_v   [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v[0] <= 1'b0;
        end else begin
            rd_v[0] <= rp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            rd_rem[0][i] <= 55'(rp_prod[i]) + 55'(rp_n >> 1);
            rd_q[0][i]   <= '0;
        end
        rd_n[0] <= rp_n;
        rd_s[0] <= rp_s;
    end

    for (genvar gd = 0; gd < DIV_STEPS; gd++) begin : g_div
        localparam int QB = DIV_STEPS - 1 - gd;
        logic [54:0] dd;

        assign dd = 55'(rd_n[gd]) << QB;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_v[gd+1] <= 1'b0;
            end else begin
                rd_v[gd+1] <= rd_v[gd];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (rd_rem[gd][i] >= dd) begin
                    rd_rem[gd+1][i] <= rd_rem[gd][i] - dd;
                    rd_q[gd+1][i]   <= rd_q[gd][i] | (23'd1 << QB);
                end else begin
                    rd_rem[gd+1][i] <= rd_rem[gd][i];
                    rd_q[gd+1][i]   <= rd_q[gd][i];
                end
            end
            rd_n[gd+1] <= rd_n[gd];
            rd_s[gd+1] <= rd_s[gd];
        end
    end

    // Tip: centroid plus signed offset, saturated to 32 bits.
    t_side              fs;
    logic [22:0]        off [3];
    logic signed [33:0] ts [3];
    t_coord             tip [3];

    always_comb begin
        fs = rd_s[DIV_STEPS];
        for (int i = 0; i < 3; i++) begin
            off[i] = fs.degen ? 23'd0 : rd_q[DIV_STEPS][i];
            ts[i]  = fs.neg[i] ? 34'(fs.cen[i]) - $signed(34'(off[i]))
                               : 34'(fs.cen[i]) + $signed(34'(off[i]));
            if (!ts[i][33] && (ts[i][32:31] != 2'b00)) begin
                tip[i] = 32'sh7FFFFFFF;
            end else if (ts[i][33] && (ts[i][32:31] != 2'b11)) begin
                tip[i] = 32'sh80000000;
            end else begin
                tip[i] = ts[i][31:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= rd_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            o_res.cen[i] <= fs.cen[i];
            o_res.tip[i] <= tip[i];
        end
        o_res.degen <= fs.degen;
        o_res.last  <= fs.last;
    end

endmodule
